@@ rtl/yrgb_pkg.sv @@
`timescale 1ns / 1ps
// yrgb_pkg: shared types and constants of the 4:2:2 to rgb pair converter
// no dependencies

package yrgb_pkg;

   localparam int COEF_FRAC_BITS_DEF = 12;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [1:0] REG_BYTE_ORDER = 2'd0;
   localparam logic [1:0] REG_COEF_SET   = 2'd1;
   localparam logic [1:0] REG_RED_OFFSET = 2'd2;

   // byte order codes
   localparam logic ORDER_UYVY = 1'b0;
   localparam logic ORDER_YUYV = 1'b1;

   // coefficient set codes
   localparam logic COEF_FULL   = 1'b0;
   localparam logic COEF_ANALOG = 1'b1;

   localparam logic signed [7:0] RED_OFFSET_RST = 8'sd8;

   typedef struct packed {
      logic              byte_order;
      logic              coefficient_set;
      logic signed [7:0] red_offset;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

endpackage

@@ rtl/yrgb_core.sv @@
`timescale 1ns / 1ps
// yrgb_core: combinational conversion of one macropixel into two rgb pixels
// depends on yrgb_pkg

module yrgb_core #(
   parameter int COEF_FRAC_BITS = yrgb_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic [31:0]       packed_word,
   input  yrgb_pkg::cfg_type cfg,
   output yrgb_pkg::pix_type pix_first,
   output yrgb_pkg::pix_type pix_second
);
   import yrgb_pkg::*;

   localparam int KW    = COEF_FRAC_BITS + 3;
   localparam int SUM_W = COEF_FRAC_BITS + 12;

   localparam longint KR_FULL  = ((64'(1402)  << COEF_FRAC_BITS) + 500)   / 1000;
   localparam longint KGU_FULL = ((64'(34413) << COEF_FRAC_BITS) + 50000) / 100000;
   localparam longint KGV_FULL = ((64'(71414) << COEF_FRAC_BITS) + 50000) / 100000;
   localparam longint KB_FULL  = ((64'(1772)  << COEF_FRAC_BITS) + 500)   / 1000;
   localparam longint KR_AN    = ((64'(1140)  << COEF_FRAC_BITS) + 500)   / 1000;
   localparam longint KGU_AN   = ((64'(395)   << COEF_FRAC_BITS) + 500)   / 1000;
   localparam longint KGV_AN   = ((64'(581)   << COEF_FRAC_BITS) + 500)   / 1000;
   localparam longint KB_AN    = ((64'(2032)  << COEF_FRAC_BITS) + 500)   / 1000;

   function automatic logic [7:0] sat8(input logic [11:0] v);
      logic [7:0] r;
      if (v[11]) begin
         r = 8'd0;
      end else if (|v[10:8]) begin
         r = 8'hff;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   logic [7:0] y0, y1, u, v;
   logic signed [8:0] du, dv;
   logic signed [KW-1:0] kr, kgu, kgv, kb;
   logic signed [SUM_W-1:0] prod_r, prod_gu, prod_gv, prod_b, off_f;
   logic signed [SUM_W-1:0] y0_f, y1_f;
   logic signed [SUM_W-1:0] r0_sum, g0_sum, b0_sum, r1_sum, g1_sum, b1_sum;

   always_comb begin
      if (cfg.byte_order == ORDER_UYVY) begin
         u  = packed_word[7:0];
         y0 = packed_word[15:8];
         v  = packed_word[23:16];
         y1 = packed_word[31:24];
      end else begin
         y0 = packed_word[7:0];
         u  = packed_word[15:8];
         y1 = packed_word[23:16];
         v  = packed_word[31:24];
      end
   end

   always_comb begin
      if (cfg.coefficient_set == COEF_ANALOG) begin
         kr  = KW'(KR_AN);
         kgu = KW'(KGU_AN);
         kgv = KW'(KGV_AN);
         kb  = KW'(KB_AN);
      end else begin
         kr  = KW'(KR_FULL);
         kgu = KW'(KGU_FULL);
         kgv = KW'(KGV_FULL);
         kb  = KW'(KB_FULL);
      end
   end

   assign du = $signed({1'b0, u}) - 9'sd128;
   assign dv = $signed({1'b0, v}) - 9'sd128;

   // chroma terms are shared by both pixels
   assign prod_r  = SUM_W'(kr * dv);
   assign prod_gu = SUM_W'(kgu * du);
   assign prod_gv = SUM_W'(kgv * dv);
   assign prod_b  = SUM_W'(kb * du);

   assign off_f = SUM_W'(cfg.red_offset) <<< COEF_FRAC_BITS;
   assign y0_f  = $signed(SUM_W'(y0)) <<< COEF_FRAC_BITS;
   assign y1_f  = $signed(SUM_W'(y1)) <<< COEF_FRAC_BITS;

   assign r0_sum = y0_f + off_f + prod_r;
   assign g0_sum = y0_f - prod_gu - prod_gv;
   assign b0_sum = y0_f + prod_b;
   assign r1_sum = y1_f + off_f + prod_r;
   assign g1_sum = y1_f - prod_gu - prod_gv;
   assign b1_sum = y1_f + prod_b;

   // dropping the fraction bits floors toward minus infinity
   assign pix_first.red    = sat8(r0_sum[SUM_W-1:COEF_FRAC_BITS]);
   assign pix_first.green  = sat8(g0_sum[SUM_W-1:COEF_FRAC_BITS]);
   assign pix_first.blue   = sat8(b0_sum[SUM_W-1:COEF_FRAC_BITS]);
   assign pix_second.red   = sat8(r1_sum[SUM_W-1:COEF_FRAC_BITS]);
   assign pix_second.green = sat8(g1_sum[SUM_W-1:COEF_FRAC_BITS]);
   assign pix_second.blue  = sat8(b1_sum[SUM_W-1:COEF_FRAC_BITS]);

endmodule

@@ rtl/yuv422_to_rgb_pair.sv @@
`timescale 1ns / 1ps
// yuv422_to_rgb_pair: top level, input register, conversion core, result register
// depends on yrgb_pkg and yrgb_core
// path: a request is held in the input register, and its result moves to the result register
// once that register is free, where it is offered until it transfers
// throughput: one macropixel per cycle unless the result side stalls, set by the
// single conversion pass between the input register and the result register
// reset: synchronous, clears both valid flags and loads the register defaults

module yuv422_to_rgb_pair #(
   parameter int COEF_FRAC_BITS = yrgb_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [31:0]                     req_packed_word,
   input  logic                            req_frame_end_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_red_first,
   output logic [7:0]                      rsp_green_first,
   output logic [7:0]                      rsp_blue_first,
   output logic [7:0]                      rsp_red_second,
   output logic [7:0]                      rsp_green_second,
   output logic [7:0]                      rsp_blue_second,
   output logic                            rsp_frame_end_out,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [yrgb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [yrgb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [yrgb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import yrgb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic [1:0] reg_idx;

   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_word_ff;
   logic        in_fe_ff;
   logic        out_valid_ff, out_valid_in;
   pix_type     out_first_ff, out_second_ff;
   logic        out_fe_ff;
   pix_type     pix_first, pix_second;
   logic        out_free, in_take;

   // register file
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            REG_BYTE_ORDER: cfg_in.byte_order      = csr_pwdata[0];
            REG_COEF_SET:   cfg_in.coefficient_set = csr_pwdata[0];
            REG_RED_OFFSET: cfg_in.red_offset      = $signed(csr_pwdata[7:0]);
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BYTE_ORDER: csr_prdata = CSR_DATA_W'(cfg_ff.byte_order);
         REG_COEF_SET:   csr_prdata = CSR_DATA_W'(cfg_ff.coefficient_set);
         REG_RED_OFFSET: csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.red_offset));
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_order      <= ORDER_UYVY;
         cfg_ff.coefficient_set <= COEF_FULL;
         cfg_ff.red_offset      <= RED_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // datapath flow control
   assign out_free     = !out_valid_ff || rsp_ready;
   assign req_ready    = !in_valid_ff || out_free;
   assign in_take      = req_valid && req_ready;
   assign in_valid_in  = in_take || (in_valid_ff && !out_free);
   assign out_valid_in = in_valid_ff || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_free ? in_valid_ff : out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_word_ff <= req_packed_word;
         in_fe_ff   <= req_frame_end_in;
      end
      if (out_free && in_valid_ff) begin
         out_first_ff  <= pix_first;
         out_second_ff <= pix_second;
         out_fe_ff     <= in_fe_ff;
      end
   end

   yrgb_core #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_core (
      .packed_word(in_word_ff),
      .cfg        (cfg_ff),
      .pix_first  (pix_first),
      .pix_second (pix_second)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_red_first     = out_first_ff.red;
   assign rsp_green_first   = out_first_ff.green;
   assign rsp_blue_first    = out_first_ff.blue;
   assign rsp_red_second    = out_second_ff.red;
   assign rsp_green_second  = out_second_ff.green;
   assign rsp_blue_second   = out_second_ff.blue;
   assign rsp_frame_end_out = out_fe_ff;

endmodule

@@ rtl/yrgb_checker.sv @@
`timescale 1ns / 1ps
// yrgb_checker: port-level assertions for yuv422_to_rgb_pair, bound to the top level
// depends on yuv422_to_rgb_pair

module yrgb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red_first,
   input logic [7:0] rsp_green_first,
   input logic [7:0] rsp_blue_first,
   input logic [7:0] rsp_red_second,
   input logic [7:0] rsp_green_second,
   input logic [7:0] rsp_blue_second,
   input logic       rsp_frame_end_out,
   input logic       csr_pready
);

   // no result offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_red_first) && $stable(rsp_green_first)
         && $stable(rsp_blue_first) && $stable(rsp_red_second)
         && $stable(rsp_green_second) && $stable(rsp_blue_second)
         && $stable(rsp_frame_end_out))
      else $error("stalled result changed");

   // request side never stalls while the result side can move
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled with free result register");

   // a request transfer made while no result is offered leads to an offered result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("result missing after request transfer");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("register port not ready");

endmodule

bind yuv422_to_rgb_pair yrgb_checker u_yrgb_checker (.*);
